@@ hdl/lag1d_pkg.sv @@
// Shared constants, widths and types of the 1D Lagrange shape function block.
// Used by every module under hdl; depends on nothing else.
package lag1d_pkg;

  // Storage and number formats
  localparam int MAX_NODES       = 4;
  localparam int COORD_FRAC_BITS = 16;
  localparam int ROW_W           = (MAX_NODES > 1) ? $clog2(MAX_NODES) : 1;
  localparam int COORD_W         = 32;
  localparam int POLY_W          = 40;
  localparam int ACC_W           = 40;
  localparam int GRAD_W          = 48;
  localparam int JAC_W           = 40;
  localparam int DQ_W            = 36;
  localparam int NUM_W           = DQ_W + COORD_FRAC_BITS;
  localparam int DIV_STEPS       = (NUM_W + 1) / 2;
  localparam int NUM_PAD         = 2 * DIV_STEPS;
  localparam int QUEUE_DEPTH     = 2;

  // Port widths
  localparam int S_TDATA_W   = 136;
  localparam int M_TDATA_W   = 128;
  localparam int CFG_INDEX_W = 1;
  localparam int CFG_DATA_W  = 16;

  // Register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_NODE_COUNT  = 1'b0;
  localparam logic [CFG_INDEX_W-1:0] REG_SING_THRESH = 1'b1;

  // Item kinds
  localparam logic MODE_LOAD = 1'b0;
  localparam logic MODE_EVAL = 1'b1;

  // One queued request, already classified by the front end
  typedef struct packed {
    logic                      mode;
    logic [1:0]                slot;
    logic signed [COORD_W-1:0] cx;
    logic signed [COORD_W-1:0] cy;
    logic signed [COORD_W-1:0] cz;
    logic signed [COORD_W-1:0] xi;
    logic                      scale;
  } lag1d_item_t;

  // Configuration seen by the back end
  typedef struct packed {
    logic [2:0]  node_count;
    logic [15:0] threshold;
  } lag1d_cfg_t;

  // Queue status towards its producer and consumer
  typedef struct packed {
    logic full;
    logic empty;
  } lag1d_qstat_t;

endpackage

@@ hdl/lag1d_front.sv @@
// Front end: accepts input requests, holds the configuration registers,
// drops out-of-range loads and saturates xi. Depends on lag1d_pkg.
module lag1d_front import lag1d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // node_slot[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66], xi[129:98],
  // scale_by_jacobian[130], zero fill above
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // mode[0]
  input  logic                   s_tuser,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  input  lag1d_qstat_t           qstat,
  output logic                   push,
  output lag1d_item_t            push_item,
  output lag1d_cfg_t             cfg
);

  localparam logic signed [COORD_W-1:0] XI_ONE = 32'sd1073741824;

  logic signed [COORD_W-1:0] xi_in;
  logic                      slot_ok;

  // Configuration writes are always taken
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.node_count <= 3'd2;
      cfg.threshold  <= 16'd1;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_NODE_COUNT:  cfg.node_count <= cfg_data[2:0];
        REG_SING_THRESH: cfg.threshold  <= cfg_data;
        default: ;
      endcase
    end
  end

  // Classify and unpack the request
  assign s_tready = !qstat.full;
  assign xi_in    = s_tdata[129:98];
  assign slot_ok  = {1'b0, s_tdata[1:0]} < 3'(MAX_NODES);

  always_comb begin
    push_item.mode  = s_tuser;
    push_item.slot  = s_tdata[1:0];
    push_item.cx    = s_tdata[33:2];
    push_item.cy    = s_tdata[65:34];
    push_item.cz    = s_tdata[97:66];
    push_item.scale = s_tdata[130];
    if (xi_in > XI_ONE) begin
      push_item.xi = XI_ONE;
    end else if (xi_in < -XI_ONE) begin
      push_item.xi = -XI_ONE;
    end else begin
      push_item.xi = xi_in;
    end
  end

  // Loads to a slot beyond the node store are dropped here
  assign push = s_tvalid && s_tready && ((s_tuser == MODE_EVAL) || slot_ok);

endmodule

@@ hdl/lag1d_queue.sv @@
// Short request queue between the front and the back end.
// Depends on lag1d_pkg.
module lag1d_queue import lag1d_pkg::*; (
  input  logic         clk,
  input  logic         rst,
  input  logic         push,
  input  lag1d_item_t  push_item,
  input  logic         pop,
  output lag1d_item_t  head,
  output lag1d_qstat_t qstat
);

  localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  lag1d_item_t        slots [QUEUE_DEPTH];
  logic [PTR_W-1:0]   wr_ptr;
  logic [PTR_W-1:0]   rd_ptr;
  logic [CNT_W-1:0]   count;

  assign qstat.full  = count == CNT_W'(QUEUE_DEPTH);
  assign qstat.empty = count == '0;
  assign head        = slots[rd_ptr];

  // Payload store
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_item;
    end
  end

  // Pointers and fill level
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

@@ hdl/lag1d_back.sv @@
// Back end: node store, shared multiplier, square root and divider sequencer,
// and the result register. Depends on lag1d_pkg.
module lag1d_back import lag1d_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  lag1d_cfg_t            cfg,
  input  lag1d_item_t           head,
  input  lag1d_qstat_t          qstat,
  output logic                  pop,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  // node_number[1:0], shape_value[33:2], shape_gradient[81:34],
  // jacobian_length[121:82], zero fill above
  output logic [M_TDATA_W-1:0]  m_tdata,
  // singular[0]
  output logic                  m_tuser,
  output logic                  m_tlast
);

  typedef enum logic [4:0] {
    S_IDLE, S_X2, S_X2R, S_X3, S_X3R, S_POLY, S_RD, S_MUL, S_ACC,
    S_MAG, S_SQ, S_SQA, S_SQRT, S_JAC, S_NODE, S_DIV, S_GSAT, S_EMIT
  } state_t;

  localparam int CNT_W = 6;
  localparam logic signed [POLY_W-1:0] ONE = 40'sd1073741824;
  localparam logic [63:0] JAC_MAX64 = (64'd1 << JAC_W) - 64'd1;
  localparam logic [NUM_PAD-1:0] GMAG = NUM_PAD'(1) << (GRAD_W - 1);

  state_t                     state;
  logic signed [COORD_W-1:0]  x, x2, x3;
  logic                       scale;
  logic [1:0]                 n_last, i, k;
  logic signed [POLY_W-1:0]   vn [4];
  logic signed [POLY_W-1:0]   dn [4];
  logic signed [ACC_W-1:0]    acc [3];
  logic [30:0]                ms [3];
  logic [3:0]                 sh;
  logic [63:0]                sum, rv, rr;
  logic [CNT_W-1:0]           cnt;
  logic [3*COORD_W-1:0]       row;
  logic [3*COORD_W-1:0]       mem [MAX_NODES];
  logic signed [67:0]         prod;
  logic [JAC_W-1:0]           jac;
  logic                       sing;
  logic [JAC_W:0]             rem;
  logic [NUM_PAD-1:0]         quo;
  logic                       neg;
  logic signed [GRAD_W-1:0]   g;

  logic signed [34:0]         mul_a;
  logic signed [32:0]         mul_b;
  logic signed [67:0]         prod_sh;
  logic [2:0]                 n_eff;
  logic signed [POLY_W-1:0]   d30, dq, v40;
  logic [POLY_W-1:0]          dqm;
  logic [ACC_W-1:0]           mg [3];
  logic [ACC_W-1:0]           mx;
  logic [3:0]                 s_sel;
  logic [63:0]                bitv;
  logic [JAC_W-1:0]           jac_n;
  logic [JAC_W:0]             rem_n;
  logic [NUM_PAD-1:0]         quo_n;
  logic signed [31:0]         v_sat;
  logic signed [POLY_W-1:0]   xe, x2e, x3e;

  // Effective node count
  always_comb begin
    if (cfg.node_count < 3'd2) begin
      n_eff = 3'd2;
    end else if (cfg.node_count > 3'd4) begin
      n_eff = 3'd4;
    end else begin
      n_eff = cfg.node_count;
    end
    if (n_eff > 3'(MAX_NODES)) begin
      n_eff = 3'(MAX_NODES);
    end
  end

  assign pop = (state == S_IDLE) && !qstat.empty;

  // Shared multiplier operand selection
  assign d30 = dn[i] >>> 4;
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state)
      S_X2: begin
        mul_a = 35'(x);
        mul_b = 33'(x);
      end
      S_X3: begin
        mul_a = 35'(x2);
        mul_b = 33'(x);
      end
      S_MUL: begin
        mul_a = d30[34:0];
        case (k)
          2'd0:    mul_b = 33'($signed(row[31:0]));
          2'd1:    mul_b = 33'($signed(row[63:32]));
          default: mul_b = 33'($signed(row[95:64]));
        endcase
      end
      S_SQ: begin
        mul_a = {4'b0, ms[k]};
        mul_b = {2'b0, ms[k]};
      end
      default: ;
    endcase
  end

  assign prod_sh = prod >>> 30;

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Magnitudes and pre-shift for the square root
  always_comb begin
    for (int c = 0; c < 3; c++) begin
      mg[c] = acc[c][ACC_W-1] ? ACC_W'(-acc[c]) : ACC_W'(acc[c]);
    end
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
    s_sel = '0;
    for (int t = 8; t >= 0; t--) begin
      if ((mx >> t) < ACC_W'(64'd1 << 31)) s_sel = 4'(t);
    end
  end

  // Square root step, Jacobian saturation
  assign bitv  = 64'd1 << {cnt, 1'b0};
  assign jac_n = (rr > (JAC_MAX64 >> sh)) ? JAC_MAX64[JAC_W-1:0] : JAC_W'(rr << sh);

  // Two restoring division steps per cycle
  always_comb begin
    rem_n = rem;
    quo_n = quo;
    for (int j = 0; j < 2; j++) begin
      rem_n = {rem_n[JAC_W-1:0], quo_n[NUM_PAD-1]};
      quo_n = quo_n << 1;
      if (rem_n >= {1'b0, jac}) begin
        rem_n    = rem_n - {1'b0, jac};
        quo_n[0] = 1'b1;
      end
    end
  end

  // Per-node derivative and value
  assign dq  = dn[i] >>> 2;
  assign dqm = dq[POLY_W-1] ? POLY_W'(-dq) : POLY_W'(dq);
  assign v40 = vn[i] >>> 4;
  always_comb begin
    if (v40 > 40'sd2147483647) begin
      v_sat = 32'sh7FFFFFFF;
    end else if (v40 < -40'sd2147483648) begin
      v_sat = 32'sh80000000;
    end else begin
      v_sat = v40[31:0];
    end
  end

  assign xe  = 40'(x);
  assign x2e = 40'(x2);
  assign x3e = 40'(x3);

  // Node coordinate store
  always_ff @(posedge clk) begin
    if (pop && head.mode == MODE_LOAD) begin
      mem[head.slot[ROW_W-1:0]] <= {head.cz, head.cy, head.cx};
    end
  end

  // Sequencer and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      // The emit state reloads the result register itself
      if (m_tvalid && m_tready && state != S_EMIT) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        S_IDLE: begin
          if (pop && head.mode == MODE_EVAL) begin
            x      <= head.xi;
            scale  <= head.scale;
            n_last <= 2'(n_eff - 3'd1);
            state  <= S_X2;
          end
        end
        S_X2:  state <= S_X2R;
        S_X2R: begin
          x2    <= prod_sh[31:0];
          state <= S_X3;
        end
        S_X3:  state <= S_X3R;
        S_X3R: begin
          x3    <= prod_sh[31:0];
          state <= S_POLY;
        end
        S_POLY: begin
          for (int c = 0; c < 3; c++) acc[c] <= '0;
          if (n_last == 2'd1) begin
            vn[0] <= 8 * (ONE - xe);
            dn[0] <= -8 * ONE;
            vn[1] <= 8 * (ONE + xe);
            dn[1] <= 8 * ONE;
            vn[2] <= '0;
            dn[2] <= '0;
            vn[3] <= '0;
            dn[3] <= '0;
          end else if (n_last == 2'd2) begin
            vn[0] <= 8 * (x2e - xe);
            dn[0] <= 8 * (2 * xe - ONE);
            vn[1] <= 16 * (ONE - x2e);
            dn[1] <= -32 * xe;
            vn[2] <= 8 * (x2e + xe);
            dn[2] <= 8 * (2 * xe + ONE);
            vn[3] <= '0;
            dn[3] <= '0;
          end else begin
            vn[0] <= -9 * x3e + 9 * x2e + xe - ONE;
            vn[1] <= 27 * x3e - 9 * x2e - 27 * xe + 9 * ONE;
            vn[2] <= -27 * x3e - 9 * x2e + 27 * xe + 9 * ONE;
            vn[3] <= 9 * x3e + 9 * x2e - xe - ONE;
            dn[0] <= -27 * x2e + 18 * xe + ONE;
            dn[1] <= 81 * x2e - 18 * xe - 27 * ONE;
            dn[2] <= -81 * x2e - 18 * xe + 27 * ONE;
            dn[3] <= 27 * x2e + 18 * xe - ONE;
          end
          i     <= '0;
          k     <= '0;
          state <= S_RD;
        end
        S_RD: begin
          row   <= mem[i[ROW_W-1:0]];
          state <= S_MUL;
        end
        S_MUL: state <= S_ACC;
        S_ACC: begin
          acc[k] <= acc[k] + prod_sh[ACC_W-1:0];
          if (i == n_last) begin
            i <= '0;
            if (k == 2'd2) begin
              state <= S_MAG;
            end else begin
              k     <= k + 1'b1;
              state <= S_RD;
            end
          end else begin
            i     <= i + 1'b1;
            state <= S_RD;
          end
        end
        S_MAG: begin
          for (int c = 0; c < 3; c++) ms[c] <= 31'(mg[c] >> s_sel);
          sh    <= s_sel;
          sum   <= '0;
          k     <= '0;
          state <= S_SQ;
        end
        S_SQ:  state <= S_SQA;
        S_SQA: begin
          sum <= sum + prod[63:0];
          if (k == 2'd2) begin
            rv    <= sum + prod[63:0];
            rr    <= '0;
            cnt   <= CNT_W'(31);
            state <= S_SQRT;
          end else begin
            k     <= k + 1'b1;
            state <= S_SQ;
          end
        end
        S_SQRT: begin
          if (rv >= rr + bitv) begin
            rv <= rv - (rr + bitv);
            rr <= (rr >> 1) + bitv;
          end else begin
            rr <= rr >> 1;
          end
          if (cnt == '0) begin
            state <= S_JAC;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_JAC: begin
          jac   <= jac_n;
          sing  <= (jac_n < JAC_W'(cfg.threshold)) || (jac_n == '0);
          i     <= '0;
          state <= S_NODE;
        end
        S_NODE: begin
          if (sing) begin
            g     <= '0;
            state <= S_EMIT;
          end else if (!scale) begin
            g     <= GRAD_W'(dq);
            state <= S_EMIT;
          end else begin
            neg   <= dq[POLY_W-1];
            rem   <= '0;
            quo   <= NUM_PAD'({dqm[DQ_W-1:0], {COORD_FRAC_BITS{1'b0}}});
            cnt   <= CNT_W'(DIV_STEPS - 1);
            state <= S_DIV;
          end
        end
        S_DIV: begin
          rem <= rem_n;
          quo <= quo_n;
          if (cnt == '0) begin
            state <= S_GSAT;
          end else begin
            cnt <= cnt - 1'b1;
          end
        end
        S_GSAT: begin
          if (neg) begin
            g <= (quo > GMAG) ? {1'b1, {(GRAD_W-1){1'b0}}} : -$signed(quo[GRAD_W-1:0]);
          end else begin
            g <= (quo > GMAG - 1'b1) ? {1'b0, {(GRAD_W-1){1'b1}}} : quo[GRAD_W-1:0];
          end
          state <= S_EMIT;
        end
        S_EMIT: begin
          if (!m_tvalid || m_tready) begin
            m_tvalid <= 1'b1;
            m_tdata  <= {6'b0, jac, g, v_sat, i};
            m_tuser  <= sing;
            m_tlast  <= (i == n_last);
            if (i == n_last) begin
              state <= S_IDLE;
            end else begin
              i     <= i + 1'b1;
              state <= S_NODE;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lagrange_1d_shape_functions.sv @@
// Top level of the 1D Lagrange shape function block: front end, request
// queue and back end. Depends on lag1d_pkg, lag1d_front, lag1d_queue, lag1d_back.
//
// Load requests (tuser 0) store one node's coordinates in the back end. An
// evaluate request (tuser 1) returns one result per node, the last one marked
// by tlast. It first forms the Jacobian: per node and axis a read, multiply
// and accumulate on the single shared multiplier, then a restoring square root
// at two bits a cycle. Each node then takes a node and an emit step when
// gradients are left local or on a singular element, or also a radix-4
// restoring divider of 26 steps and a saturation step when gradients are
// divided by the Jacobian length. The back end works on one request at a time,
// and a two-entry queue lets the front end keep accepting meanwhile.
module lagrange_1d_shape_functions import lag1d_pkg::*; (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_tvalid,
  output logic                   s_tready,
  // node_slot[1:0], coord_x[33:2], coord_y[65:34], coord_z[97:66], xi[129:98],
  // scale_by_jacobian[130], zero fill above
  input  logic [S_TDATA_W-1:0]   s_tdata,
  // mode[0]
  input  logic                   s_tuser,
  output logic                   m_tvalid,
  input  logic                   m_tready,
  // node_number[1:0], shape_value[33:2], shape_gradient[81:34],
  // jacobian_length[121:82], zero fill above
  output logic [M_TDATA_W-1:0]   m_tdata,
  // singular[0]
  output logic                   m_tuser,
  output logic                   m_tlast,
  input  logic                   cfg_valid,
  output logic                   cfg_ready,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  logic         push;
  logic         pop;
  lag1d_item_t  push_item;
  lag1d_item_t  head;
  lag1d_qstat_t qstat;
  lag1d_cfg_t   cfg;

  // Request intake and configuration
  lag1d_front u_front (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tuser   (s_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .qstat     (qstat),
    .push      (push),
    .push_item (push_item),
    .cfg       (cfg)
  );

  // Decoupling queue
  lag1d_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_item (push_item),
    .pop       (pop),
    .head      (head),
    .qstat     (qstat)
  );

  // Execution and results
  lag1d_back u_back (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg),
    .head     (head),
    .qstat    (qstat),
    .pop      (pop),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

@@ tb/lagrange_1d_shape_functions_tb.sv @@
// Self-checking testbench for the 1D Lagrange shape function block.
// Depends on lag1d_pkg and lagrange_1d_shape_functions; predicts every result in-house.
module lagrange_1d_shape_functions_tb;
  import lag1d_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  localparam longint ONE_Q30    = 64'sd1 << 30;
  localparam longint GRAD_TOP   = (64'sd1 <<< 47) - 1;
  localparam longint GRAD_BOT   = -(64'sd1 <<< 47);
  localparam longint JAC_TOP    = (64'sd1 <<< 40) - 1;
  localparam int     SETTLE     = 250;
  localparam int     STALL_MAX  = 5000;

  typedef struct {
    logic [1:0]  node;
    logic [31:0] value;
    logic [47:0] grad;
    logic [39:0] jac;
    logic        sing;
    logic        last;
  } shape_result_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [S_TDATA_W-1:0]   s_tdata = '0;
  logic                   s_tuser = 1'b0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [M_TDATA_W-1:0]   m_tdata;
  logic                   m_tuser;
  logic                   m_tlast;
  logic                   cfg_valid = 1'b0;
  logic                   cfg_ready;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data = '0;

  // Shadow state of the block
  logic signed [31:0] node_xyz [4][3];
  logic [2:0]         node_count_reg = 3'd2;
  logic [15:0]        threshold_reg = 16'd1;

  shape_result_t pending_results[$];
  int  errors = 0;
  int  items_sent = 0;
  int  results_seen = 0;
  int  singular_seen = 0;
  int  send_idle_pct = 0;
  int  recv_stall_pct = 0;
  int  hold_off = 0;
  int  quiet_cycles = 0;

  lagrange_1d_shape_functions dut (.*);

  always #6 clk = ~clk;

  // floor(a*b / 2^s) without overflow
  function automatic longint mul_floor(longint a, longint b, int s);
    logic signed [127:0] pa, pb, p;
    pa = a;
    pb = b;
    p = pa * pb;
    return longint'(p >>> s);
  endfunction

  function automatic longint unsigned int_sqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v -= r + b;
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Work out the results of one evaluate request and queue them.
  function automatic void predict_shapes(logic [31:0] xi_raw, logic scale);
    longint x, x2, x3, vn[4], dn[4], comp, v, dq, g;
    longint unsigned mg[3], mx, sum, jac;
    int n, s;
    bit sing;
    shape_result_t r;
    n = node_count_reg < 2 ? 2 : (node_count_reg > 4 ? 4 : int'(node_count_reg));
    x = longint'($signed(xi_raw));
    if (x > ONE_Q30) x = ONE_Q30;
    if (x < -ONE_Q30) x = -ONE_Q30;
    x2 = mul_floor(x, x, 30);
    x3 = mul_floor(x2, x, 30);
    if (n == 2) begin
      vn[0] = 8 * (ONE_Q30 - x);   dn[0] = -8 * ONE_Q30;
      vn[1] = 8 * (ONE_Q30 + x);   dn[1] = 8 * ONE_Q30;
    end else if (n == 3) begin
      vn[0] = 8 * (x2 - x);        dn[0] = 8 * (2 * x - ONE_Q30);
      vn[1] = 16 * (ONE_Q30 - x2); dn[1] = -32 * x;
      vn[2] = 8 * (x2 + x);        dn[2] = 8 * (2 * x + ONE_Q30);
    end else begin
      vn[0] = -9 * x3 + 9 * x2 + x - ONE_Q30;
      vn[1] = 27 * x3 - 9 * x2 - 27 * x + 9 * ONE_Q30;
      vn[2] = -27 * x3 - 9 * x2 + 27 * x + 9 * ONE_Q30;
      vn[3] = 9 * x3 + 9 * x2 - x - ONE_Q30;
      dn[0] = -27 * x2 + 18 * x + ONE_Q30;
      dn[1] = 81 * x2 - 18 * x - 27 * ONE_Q30;
      dn[2] = -81 * x2 - 18 * x + 27 * ONE_Q30;
      dn[3] = 27 * x2 + 18 * x - ONE_Q30;
    end
    // Jacobian components and their length, pre-shifted to keep the squares in range
    for (int k = 0; k < 3; k++) begin
      comp = 0;
      for (int i = 0; i < n; i++)
        comp += mul_floor(dn[i] >>> 4, longint'(node_xyz[i][k]), 30);
      mg[k] = comp < 0 ? longint'(-comp) : longint'(comp);
    end
    mx = mg[0];
    if (mg[1] > mx) mx = mg[1];
    if (mg[2] > mx) mx = mg[2];
    s = 0;
    while ((mx >> s) >= (64'd1 << 31)) s++;
    sum = 0;
    for (int k = 0; k < 3; k++) sum += (mg[k] >> s) * (mg[k] >> s);
    jac = int_sqrt(sum);
    if (jac > (JAC_TOP >> s)) jac = JAC_TOP;
    else jac <<= s;
    sing = (jac < threshold_reg) || (jac == 0);
    for (int i = 0; i < n; i++) begin
      v = vn[i] >>> 4;
      if (v > 64'sd2147483647) v = 64'sd2147483647;
      if (v < -64'sd2147483648) v = -64'sd2147483648;
      dq = dn[i] >>> 2;
      if (sing) g = 0;
      else if (scale) g = (dq * 65536) / longint'(jac);
      else g = dq;
      if (g > GRAD_TOP) g = GRAD_TOP;
      if (g < GRAD_BOT) g = GRAD_BOT;
      r.node  = i[1:0];
      r.value = v[31:0];
      r.grad  = g[47:0];
      r.jac   = jac[39:0];
      r.sing  = sing;
      r.last  = (i == n - 1);
      pending_results.push_back(r);
    end
  endfunction

  // Offer one request and track it once accepted; starts and ends just after a falling edge.
  task automatic send_request(logic mode, logic [1:0] slot, logic [31:0] cx, logic [31:0] cy,
                              logic [31:0] cz, logic [31:0] xi, logic scale);
    while ($urandom_range(99, 0) < send_idle_pct) begin
      s_tvalid = 1'b0;
      @(negedge clk);
    end
    s_tuser = mode;
    s_tdata = '0;
    s_tdata[1:0]     = slot;
    s_tdata[33:2]    = cx;
    s_tdata[65:34]   = cy;
    s_tdata[97:66]   = cz;
    s_tdata[129:98]  = xi;
    s_tdata[130]     = scale;
    s_tvalid = 1'b1;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    items_sent++;
    if (mode == MODE_LOAD) begin
      node_xyz[slot][0] = cx;
      node_xyz[slot][1] = cy;
      node_xyz[slot][2] = cz;
    end else begin
      predict_shapes(xi, scale);
    end
    @(negedge clk);
    s_tvalid = 1'b0;
  endtask

  task automatic load_node(logic [1:0] slot, logic [31:0] cx, logic [31:0] cy, logic [31:0] cz);
    send_request(MODE_LOAD, slot, cx, cy, cz, $urandom, $urandom_range(1, 0));
  endtask

  task automatic evaluate(logic [31:0] xi, logic scale);
    send_request(MODE_EVAL, $urandom_range(3, 0), $urandom, $urandom, $urandom, xi, scale);
  endtask

  task automatic wait_drained();
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  // Register writes happen only with the block idle, loads included.
  task automatic write_reg(logic [CFG_INDEX_W-1:0] idx, logic [15:0] data);
    wait_drained();
    repeat (SETTLE) @(negedge clk);
    cfg_index = idx;
    cfg_data  = data;
    cfg_valid = 1'b1;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == REG_NODE_COUNT) node_count_reg = data[2:0];
    else threshold_reg = data;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  function automatic logic [31:0] random_xi();
    if ($urandom_range(9, 0) < 2) return $urandom;
    return 32'($urandom_range(32'h8000_0000, 0)) - 32'h4000_0000;
  endfunction

  function automatic logic [31:0] random_coord();
    if ($urandom_range(3, 0) == 0) return $urandom;
    return 32'($urandom_range(32'h0020_0000, 0)) - 32'h0010_0000;
  endfunction

  // Extremes of every field, each element order and the singular element
  task automatic test_directed();
    load_node(2'd0, 32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    load_node(2'd1, 32'h0001_0000, 32'h0000_0000, 32'h0000_0000);
    load_node(2'd2, 32'h0002_0000, 32'h0001_0000, 32'h0000_0000);
    load_node(2'd3, 32'h0003_0000, 32'h0000_0000, 32'hFFFF_0000);
    evaluate(32'hC000_0000, 1'b0);
    evaluate(32'h4000_0000, 1'b1);
    evaluate(32'h0000_0000, 1'b1);
    evaluate(32'h7FFF_FFFF, 1'b1);
    evaluate(32'h8000_0000, 1'b0);
    write_reg(REG_NODE_COUNT, 16'd3);
    evaluate(32'h2000_0000, 1'b1);
    evaluate(32'hE000_0000, 1'b0);
    write_reg(REG_NODE_COUNT, 16'd4);
    evaluate(32'h1555_5555, 1'b1);
    evaluate(32'hC000_0000, 1'b1);
    load_node(2'd3, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    evaluate(32'h4000_0000, 1'b1);
    // Collapsed element gives a zero length
    for (int i = 0; i < 4; i++) load_node(i[1:0], 32'h0, 32'h0, 32'h0);
    evaluate(32'h1000_0000, 1'b1);
    // Node counts outside the valid range fall back to the nearest order
    write_reg(REG_NODE_COUNT, 16'hFFF8);
    evaluate(32'h0, 1'b0);
    write_reg(REG_NODE_COUNT, 16'd7);
    evaluate(32'h0, 1'b0);
    for (int i = 0; i < 4; i++) load_node(i[1:0], 32'(i) << 14, 32'h0, 32'h0);
    write_reg(REG_SING_THRESH, 16'hFFFF);
    evaluate(32'h0, 1'b1);
    write_reg(REG_SING_THRESH, 16'h0000);
    evaluate(32'h0, 1'b1);
  endtask

  // Receiver holds off long enough that the queue fills, then the sender waits for all results.
  task automatic test_backpressure();
    write_reg(REG_NODE_COUNT, 16'd4);
    write_reg(REG_SING_THRESH, 16'd1);
    send_idle_pct = 0;
    hold_off = 600;
    for (int i = 0; i < 8; i++) evaluate(random_xi(), 1'b1);
    wait_drained();
  endtask

  task automatic test_random();
    int send_mix[4] = '{0, 67, 0, 15};
    int recv_mix[4] = '{0, 0, 67, 15};
    int counts[4]   = '{2, 3, 4, 5};
    for (int ph = 0; ph < 4; ph++) begin
      write_reg(REG_NODE_COUNT, {13'($urandom), 3'(counts[ph])});
      write_reg(REG_SING_THRESH, ph == 3 ? 16'hFFFF : 16'($urandom_range(200, 0)));
      send_idle_pct  = send_mix[ph];
      recv_stall_pct = recv_mix[ph];
      for (int i = 0; i < 60; i++) begin
        if ($urandom_range(99, 0) < 35)
          load_node($urandom_range(3, 0), random_coord(), random_coord(), random_coord());
        else
          evaluate(random_xi(), $urandom_range(1, 0));
      end
    end
    send_idle_pct  = 0;
    recv_stall_pct = 0;
  endtask

  // Receiver readiness, with an optional long hold-off
  always @(negedge clk) begin
    if (hold_off > 0) begin
      hold_off--;
      m_tready = 1'b0;
    end else begin
      m_tready = $urandom_range(99, 0) >= recv_stall_pct;
    end
  end

  // Compare each result against the oldest prediction
  always @(posedge clk) begin
    shape_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      results_seen++;
      if (m_tuser) singular_seen++;
      if (pending_results.size() == 0) begin
        $error("unexpected result: node %0d", m_tdata[1:0]);
        errors++;
      end else begin
        want = pending_results.pop_front();
        if (m_tdata[1:0] !== want.node) begin
          $error("node_number: expected %0d, got %0d", want.node, m_tdata[1:0]);
          errors++;
        end
        if (m_tdata[33:2] !== want.value) begin
          $error("shape_value: expected %h, got %h", want.value, m_tdata[33:2]);
          errors++;
        end
        if (m_tdata[81:34] !== want.grad) begin
          $error("shape_gradient: expected %h, got %h", want.grad, m_tdata[81:34]);
          errors++;
        end
        if (m_tdata[121:82] !== want.jac) begin
          $error("jacobian_length: expected %h, got %h", want.jac, m_tdata[121:82]);
          errors++;
        end
        if (m_tuser !== want.sing) begin
          $error("singular: expected %0d, got %0d", want.sing, m_tuser);
          errors++;
        end
        if (m_tlast !== want.last) begin
          $error("last_node: expected %0d, got %0d", want.last, m_tlast);
          errors++;
        end
      end
    end
  end

  // Stop the run if no request moves on any channel for too long
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_MAX) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    repeat (2) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    test_directed();
    test_backpressure();
    test_random();
    wait_drained();
    repeat (SETTLE) @(posedge clk);
    $display("Covered %0d requests and %0d results (%0d singular) over all orders,",
             items_sent, results_seen, singular_seen);
    $display("thresholds from 0 to 65535, and idle, stalled and held-off phases.");
    if (errors == 0 && pending_results.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
